/* design/ffba_pkg.sv */
package ffba_pkg;

  localparam int ADDR_W  = 32;
  localparam int BIU_W   = 11;
  localparam int STAT_W  = 2;
  localparam int MARK_W  = 3;

  // Reset value of the blocks_in_use register.
  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

  // Bit positions inside one table entry.
  localparam int MARK_TAKEN = 0;
  localparam int MARK_FIRST = 1;
  localparam int MARK_NEXT  = 2;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOMEM = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;

  // Register select, taken from paddr[2].
  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_BLOCKS    = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_LOCATE,
    ST_WALK,
    ST_RESULT
  } state_t;

endpackage

/* design/first_fit_block_allocator.sv */
// First-fit block allocator over a table of MAX_BLOCKS marks, one per block of
// BLOCK_BYTES bytes.
// Input channel: in_valid/in_stall with in_kind (0 allocate, 1 free),
// in_size_bytes and in_free_address. One beat in gives exactly one beat out on
// out_valid/out_stall: out_granted_address and out_status (ok, no memory, bad).
// Configuration: APB write at 0x0 sets heap_base, at 0x4 blocks_in_use. Write
// only while no request is in flight.
// Timing: one request at a time. A single adder (running offset plus
// BLOCK_BYTES) walks the table one entry per cycle through a memory with a
// registered read port. Allocate: a scan of up to n entries, with
// n = min(blocks_in_use, MAX_BLOCKS), then each block of the run marked,
// then the result state. Free: index search up to the block that holds the
// address, then each entry of the chain cleared, then the result state.
// Zero-size allocate goes straight to the result state.
// Reset: a clearing pass writes every entry to free, with in_stall high;
// configuration writes are taken during it.
// Stall: the result sits in an output register. The next request may be
// accepted while it waits; that request holds in its result cycle until the
// output register frees up.
module first_fit_block_allocator #(
  parameter int BLOCK_BYTES = 4096,
  parameter int MAX_BLOCKS  = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [ffba_pkg::ADDR_W-1:0]    in_size_bytes,
  input  logic [ffba_pkg::ADDR_W-1:0]    in_free_address,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ffba_pkg::ADDR_W-1:0]    out_granted_address,
  output logic [ffba_pkg::STAT_W-1:0]    out_status,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int NW = (CW > ffba_pkg::BIU_W) ? CW : ffba_pkg::BIU_W;
  localparam int PW = $clog2(MAX_BLOCKS) + $clog2(BLOCK_BYTES) + 1;
  localparam int LW = ((PW > ffba_pkg::ADDR_W) ? PW : ffba_pkg::ADDR_W) + 1;

  // Control registers
  ffba_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] pos_r, pos_nxt;          // idx_r * BLOCK_BYTES while scanning or locating
  logic          in_run_r, in_run_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers
  logic [CW-1:0] start_r, start_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic [LW-1:0] start_bytes_r, start_bytes_nxt;
  logic [LW-1:0] target_r, target_nxt;   // start offset plus request size
  logic [ffba_pkg::ADDR_W-1:0] size_r, size_nxt;
  logic [ffba_pkg::ADDR_W-1:0] off_r, off_nxt;
  logic [ffba_pkg::ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [ffba_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [ffba_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [ffba_pkg::STAT_W-1:0] out_status_r, out_status_nxt;

  // Configuration
  logic [ffba_pkg::ADDR_W-1:0] heap_base_r;
  logic [ffba_pkg::BIU_W-1:0]  biu_r;

  // Mark table
  logic [ffba_pkg::MARK_W-1:0] marks_mem [MAX_BLOCKS];
  logic [ffba_pkg::MARK_W-1:0] rd_q;
  logic [AW-1:0]               mem_ra;
  logic [AW-1:0]               mem_wa;
  logic [ffba_pkg::MARK_W-1:0] mem_wd;
  logic                        mem_we;

  // Shared unit and decision terms
  logic [LW-1:0] bb;
  logic [LW-1:0] pos_sum;
  logic [LW-1:0] tgt;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] n_len;
  logic          in_acc;
  logic          slot_free;
  logic          scan_end;
  logic          entry_free;
  logic          run_done;
  logic          loc_hit;
  logic          walk_last;
  logic          mark_last;
  logic          clear_last;
  logic          cfg_wr;

  // Effective table length: min(blocks_in_use, MAX_BLOCKS)
  assign n_len = (NW'(biu_r) > NW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(biu_r);

  assign bb         = LW'(BLOCK_BYTES);
  assign pos_sum    = pos_r + bb;
  assign idx_inc    = idx_r + 1'b1;
  assign tgt        = in_run_r ? target_r : (pos_r + LW'(size_r));
  assign scan_end   = (idx_r >= n_len);
  assign entry_free = (rd_q == '0);
  assign run_done   = (pos_sum >= tgt);           // run covers the request
  assign loc_hit    = (LW'(off_r) < pos_sum);     // offset falls in block idx_r
  assign walk_last  = !rd_q[ffba_pkg::MARK_NEXT] || (idx_inc >= n_len);
  assign mark_last  = (idx_r == end_r);
  assign clear_last = (idx_r == CW'(MAX_BLOCKS - 1));
  assign slot_free  = !out_valid_r || !out_stall;

  assign in_stall = (state_r != ffba_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffba_pkg::ST_CLEAR: begin
        if (clear_last) state_nxt = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == ffba_pkg::KIND_FREE) state_nxt = ffba_pkg::ST_LOCATE;
          else if (in_size_bytes == '0)       state_nxt = ffba_pkg::ST_RESULT;
          else                                state_nxt = ffba_pkg::ST_SCAN;
        end
      end
      ffba_pkg::ST_SCAN: begin
        if (scan_end)                    state_nxt = ffba_pkg::ST_RESULT;
        else if (entry_free && run_done) state_nxt = ffba_pkg::ST_MARK;
      end
      ffba_pkg::ST_MARK: begin
        if (mark_last) state_nxt = ffba_pkg::ST_RESULT;
      end
      ffba_pkg::ST_LOCATE: begin
        if (scan_end)     state_nxt = ffba_pkg::ST_RESULT;
        else if (loc_hit) state_nxt = ffba_pkg::ST_WALK;
      end
      ffba_pkg::ST_WALK: begin
        if (walk_last) state_nxt = ffba_pkg::ST_RESULT;
      end
      ffba_pkg::ST_RESULT: begin
        if (slot_free) state_nxt = ffba_pkg::ST_IDLE;
      end
      default: state_nxt = ffba_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    in_run_nxt      = in_run_r;
    start_nxt       = start_r;
    end_nxt         = end_r;
    start_bytes_nxt = start_bytes_r;
    target_nxt      = target_r;
    size_nxt        = size_r;
    off_nxt         = off_r;
    res_addr_nxt    = res_addr_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_addr_nxt    = out_addr_r;
    out_status_nxt  = out_status_r;
    mem_we          = 1'b0;
    mem_wa          = idx_r[AW-1:0];
    mem_wd          = '0;
    mem_ra          = idx_r[AW-1:0];

    case (state_r)
      ffba_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        idx_nxt = clear_last ? '0 : idx_inc;
      end
      ffba_pkg::ST_IDLE: begin
        mem_ra         = '0;   // prime the scan with entry zero
        idx_nxt        = '0;
        pos_nxt        = '0;
        in_run_nxt     = 1'b0;
        size_nxt       = in_size_bytes;
        off_nxt        = in_free_address - heap_base_r;
        res_addr_nxt   = '0;
        res_status_nxt = ffba_pkg::STAT_BAD;
      end
      ffba_pkg::ST_SCAN: begin
        mem_ra = idx_inc[AW-1:0];
        if (scan_end) begin
          res_addr_nxt   = '0;
          res_status_nxt = ffba_pkg::STAT_NOMEM;
        end else if (!entry_free) begin
          in_run_nxt = 1'b0;
          idx_nxt    = idx_inc;
          pos_nxt    = pos_sum;
        end else begin
          if (!in_run_r) begin
            start_nxt       = idx_r;
            start_bytes_nxt = pos_r;
            target_nxt      = tgt;
            in_run_nxt      = 1'b1;
          end
          if (run_done) begin
            end_nxt = idx_r;
            idx_nxt = in_run_r ? start_r : idx_r;
          end else begin
            idx_nxt = idx_inc;
            pos_nxt = pos_sum;
          end
        end
      end
      ffba_pkg::ST_MARK: begin
        mem_we                       = 1'b1;
        mem_wd[ffba_pkg::MARK_TAKEN] = 1'b1;
        mem_wd[ffba_pkg::MARK_FIRST] = (idx_r == start_r);
        mem_wd[ffba_pkg::MARK_NEXT]  = !mark_last;
        if (mark_last) begin
          res_addr_nxt   = heap_base_r + start_bytes_r[ffba_pkg::ADDR_W-1:0];
          res_status_nxt = ffba_pkg::STAT_OK;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ffba_pkg::ST_LOCATE: begin
        // read of idx_r issued here feeds the first walk cycle
        if (scan_end) begin
          res_addr_nxt   = '0;
          res_status_nxt = ffba_pkg::STAT_BAD;
        end else if (!loc_hit) begin
          idx_nxt = idx_inc;
          pos_nxt = pos_sum;
        end
      end
      ffba_pkg::ST_WALK: begin
        mem_ra = idx_inc[AW-1:0];
        mem_we = 1'b1;
        if (walk_last) begin
          res_addr_nxt   = '0;
          res_status_nxt = ffba_pkg::STAT_OK;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ffba_pkg::ST_RESULT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffba_pkg::ST_CLEAR;
      idx_r       <= '0;
      pos_r       <= '0;
      in_run_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      in_run_r    <= in_run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r       <= start_nxt;
    end_r         <= end_nxt;
    start_bytes_r <= start_bytes_nxt;
    target_r      <= target_nxt;
    size_r        <= size_nxt;
    off_r         <= off_nxt;
    res_addr_r    <= res_addr_nxt;
    res_status_r  <= res_status_nxt;
    out_addr_r    <= out_addr_nxt;
    out_status_r  <= out_status_nxt;
  end

  // Mark table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      marks_mem[mem_wa] <= mem_wd;
    end
    rd_q <= marks_mem[mem_ra];
  end

  // APB registers; low address bits are byte lanes and ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ffba_pkg::REG_BLOCKS) ? 32'(biu_r) : heap_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
      biu_r       <= ffba_pkg::BIU_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ffba_pkg::REG_HEAP_BASE) heap_base_r <= pwdata;
      else                                     biu_r <= pwdata[ffba_pkg::BIU_W-1:0];
    end
  end

  // Checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in flight");

  a_zero_addr_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ffba_pkg::STAT_OK) |-> out_granted_address == '0)
    else $error("nonzero address on a failed request");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ffba_pkg::STAT_OK) || (out_status == ffba_pkg::STAT_NOMEM)
                  || (out_status == ffba_pkg::STAT_BAD))
    else $error("undefined status code");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ffba_pkg::ST_CLEAR) || (state_r == ffba_pkg::ST_MARK)
               || (state_r == ffba_pkg::ST_WALK))
    else $error("table write outside clear, mark or walk");

  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffba_pkg::ST_WALK) || (state_r == ffba_pkg::ST_MARK) |-> idx_r < n_len)
    else $error("table index past the table length");

endmodule

/* dv/testbench.sv */
module testbench;

  // Geometry of the instance under test, passed down as parameters.
  localparam int BLOCK_BYTES = 4096;
  localparam int MAX_BLOCKS  = 1024;

  // Run bounds. The slowest legal beat is a full scan plus a full mark, plus
  // the worst gap and stall on each side. The limit is that, times all the
  // requests, times about four.
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUEUE_AHEAD  = 4;
  localparam int POOL_DEPTH   = 64;

  // APB byte addresses of the two registers.
  localparam logic [2:0] ADDR_HEAP_BASE = {ffba_pkg::REG_HEAP_BASE, 2'b00};
  localparam logic [2:0] ADDR_BLOCKS    = {ffba_pkg::REG_BLOCKS, 2'b00};

  typedef struct packed {
    logic                        kind;
    logic [ffba_pkg::ADDR_W-1:0] size_bytes;
    logic [ffba_pkg::ADDR_W-1:0] free_address;
  } request_t;

  typedef struct packed {
    logic [ffba_pkg::ADDR_W-1:0] granted_address;
    logic [ffba_pkg::STAT_W-1:0] status;
  } grant_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_kind = ffba_pkg::KIND_ALLOC;
  logic [ffba_pkg::ADDR_W-1:0] in_size_bytes = '0;
  logic [ffba_pkg::ADDR_W-1:0] in_free_address = '0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [ffba_pkg::ADDR_W-1:0] out_granted_address;
  logic [ffba_pkg::STAT_W-1:0] out_status;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  initial begin
    forever #2 clk = ~clk;
  end

  first_fit_block_allocator #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_size_bytes      (in_size_bytes),
    .in_free_address    (in_free_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_granted_address(out_granted_address),
    .out_status         (out_status),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: mark table plus the two registers
  // ---------------------------------------------------------------------------
  logic [ffba_pkg::MARK_W-1:0] mark_table [MAX_BLOCKS] = '{default: '0};
  logic [ffba_pkg::ADDR_W-1:0] shadow_base   = '0;
  logic [ffba_pkg::BIU_W-1:0]  shadow_blocks = ffba_pkg::BIU_RESET;

  request_t                    pending_requests [$];  // stimulus not yet offered
  grant_t                      grants_due [$];        // predicted results, oldest first
  logic [ffba_pkg::ADDR_W-1:0] live_grants [$];       // granted addresses, feed for frees

  int unsigned allocs_granted = 0;
  int unsigned allocs_refused = 0;
  int unsigned bad_requests   = 0;
  int unsigned frees_done     = 0;
  int unsigned beats_sent     = 0;
  int unsigned beats_checked  = 0;
  int unsigned mismatches     = 0;
  int unsigned settings_tried = 0;
  int unsigned cycle_count    = 0;

  bit          idle_enable = 1'b1;  // random gaps and stalls on or off
  logic        hold_arm = 1'b0;     // pulse: start a long receiver hold-off
  int unsigned hold_left = 0;

  // Entries actually covered: blocks_in_use clamped to the table depth.
  function automatic int unsigned window_blocks();
    return (shadow_blocks > MAX_BLOCKS) ? MAX_BLOCKS : shadow_blocks;
  endfunction

  // Apply one request to the shadow table and return the result it gives.
  function automatic grant_t apply_request(request_t r);
    grant_t                      g;
    int unsigned                 n;
    int unsigned                 run;
    int unsigned                 start;
    int unsigned                 blk;
    longint unsigned             need;
    logic [ffba_pkg::ADDR_W-1:0] offset;
    logic [ffba_pkg::MARK_W-1:0] mark_entry;
    bit                          found;
    bit                          done;
    n = window_blocks();
    g.granted_address = '0;
    g.status = ffba_pkg::STAT_OK;
    run = 0;
    start = 0;
    found = 1'b0;
    done = 1'b0;
    if (r.kind == ffba_pkg::KIND_ALLOC) begin
      // round up to whole blocks, in 64 bits so a huge size can't wrap
      need = ({32'd0, r.size_bytes} + BLOCK_BYTES - 1) / BLOCK_BYTES;
      if (r.size_bytes == '0) begin
        g.status = ffba_pkg::STAT_BAD;
      end else if (need > n) begin
        g.status = ffba_pkg::STAT_NOMEM;
      end else begin
        // first fit: lowest run of free entries, only inside the table
        for (int i = 0; i < n && !found; i++) begin
          if (mark_table[i] != '0) begin
            run = 0;
          end else begin
            if (run == 0) start = i;
            run++;
            if (run == need) found = 1'b1;
          end
        end
        if (!found) begin
          g.status = ffba_pkg::STAT_NOMEM;
        end else begin
          for (int k = 0; k < need; k++) begin
            mark_entry = '0;
            mark_entry[ffba_pkg::MARK_TAKEN] = 1'b1;
            mark_entry[ffba_pkg::MARK_FIRST] = (k == 0);
            mark_entry[ffba_pkg::MARK_NEXT]  = (k + 1 < need);
            mark_table[start + k] = mark_entry;
          end
          g.granted_address = shadow_base + 32'(start * BLOCK_BYTES);
        end
      end
      if (g.status == ffba_pkg::STAT_OK) begin
        allocs_granted++;
        live_grants.push_back(g.granted_address);
        if (live_grants.size() > POOL_DEPTH) void'(live_grants.pop_front());
      end
    end else begin
      // below the base wraps to a huge offset and lands out of range
      offset = r.free_address - shadow_base;
      blk = offset / BLOCK_BYTES;
      if (blk >= n) begin
        g.status = ffba_pkg::STAT_BAD;
      end else begin
        // clear along has-next; the walk never leaves the table
        for (int i = blk; i < n && !done; i++) begin
          mark_entry = mark_table[i];
          mark_table[i] = '0;
          done = !mark_entry[ffba_pkg::MARK_NEXT];
        end
        frees_done++;
      end
    end
    if (g.status == ffba_pkg::STAT_NOMEM) allocs_refused++;
    if (g.status == ffba_pkg::STAT_BAD) bad_requests++;
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Gap after a beat: mostly none, some short, a few long.
  function automatic int unsigned pick_pause();
    int unsigned roll;
    if (!idle_enable) return 0;
    roll = $urandom_range(0, 15);
    if (roll < 9) return 0;
    if (roll < 15) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The field a request ignores still carries random bits.
  task automatic queue_alloc(input logic [ffba_pkg::ADDR_W-1:0] size_bytes);
    pending_requests.push_back('{ffba_pkg::KIND_ALLOC, size_bytes, $urandom});
  endtask

  task automatic queue_free(input logic [ffba_pkg::ADDR_W-1:0] address);
    pending_requests.push_back('{ffba_pkg::KIND_FREE, $urandom, address});
  endtask

  // Mostly allocations of a few blocks and frees of live regions, with some
  // zero sizes, oversize requests, misaligned and wild free addresses.
  function automatic request_t random_request();
    request_t    r;
    int unsigned n;
    int unsigned cap;
    int unsigned roll;
    int unsigned pick;
    n = window_blocks();
    cap = (n < 8) ? ((n == 0) ? 1 : n) : n / 4;
    r.size_bytes = $urandom;
    r.free_address = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      r.kind = ffba_pkg::KIND_ALLOC;
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        r.size_bytes = '0;
      end else if (roll == 2) begin
        // right at the table size, or one block past it
        r.size_bytes = 32'((n + $urandom_range(0, 1)) * BLOCK_BYTES
                           - $urandom_range(0, BLOCK_BYTES - 1));
      end else if (roll != 1) begin
        r.size_bytes = 32'(($urandom_range(1, cap) - 1) * BLOCK_BYTES
                           + $urandom_range(1, BLOCK_BYTES));
      end
    end else begin
      r.kind = ffba_pkg::KIND_FREE;
      roll = $urandom_range(0, 9);
      if (roll < 6 && live_grants.size() != 0) begin
        pick = $urandom_range(0, live_grants.size() - 1);
        r.free_address = live_grants[pick]
                         + ((roll == 0) ? $urandom_range(0, BLOCK_BYTES - 1) : 0);
        live_grants.delete(pick);
      end else if (roll < 9) begin
        // any block of the table, or the first one past it
        r.free_address = shadow_base + 32'($urandom_range(0, n) * BLOCK_BYTES
                                           + $urandom_range(0, BLOCK_BYTES - 1));
      end
    end
    return r;
  endfunction

  // Keep a short queue ahead of the driver so frees can reuse fresh grants.
  task automatic feed_random(input int count);
    for (int k = 0; k < count; k++) begin
      while (pending_requests.size() >= QUEUE_AHEAD) @(posedge clk);
      pending_requests.push_back(random_request());
    end
  endtask

  // Quiet means nothing queued, nothing offered and nothing owed. Looked at
  // on the falling edge so the rising-edge updates have all landed.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || grants_due.size() != 0);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // New heap window, written only once the block has gone quiet.
  task automatic reconfigure(input logic [ffba_pkg::ADDR_W-1:0] base,
                             input logic [ffba_pkg::BIU_W-1:0] blocks);
    wait_idle();
    write_reg(ADDR_HEAP_BASE, base);
    shadow_base = base;
    write_reg(ADDR_BLOCKS, 32'(blocks));
    shadow_blocks = blocks;
    live_grants.delete();
    settings_tried++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: offers one beat at a time from pending_requests. The
  // payload holds while stalled; the prediction is made at the accepting edge.
  // ---------------------------------------------------------------------------
  request_t    offered;
  int unsigned send_pause = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_pause = 0;
    end else begin
      if (in_valid && !in_stall) begin
        grants_due.push_back(apply_request(offered));
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_pause != 0) begin
          send_pause--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          offered = pending_requests.pop_front();
          in_kind         <= offered.kind;
          in_size_bytes   <= offered.size_bytes;
          in_free_address <= offered.free_address;
          in_valid        <= 1'b1;
          send_pause = pick_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off on the result side, counted here on its own
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted beat against the oldest prediction,
  // then picks the stall for the next cycle.
  // ---------------------------------------------------------------------------
  int unsigned recv_left = 0;
  bit          recv_busy = 1'b0;

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_left = 0;
      recv_busy = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (grants_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: addr %h status %0d",
                     out_granted_address, out_status);
        end else begin
          want = grants_due.pop_front();
          if (out_granted_address !== want.granted_address ||
              out_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result beat %0d: expected addr %h status %0d, got addr %h status %0d",
                       beats_checked, want.granted_address, want.status,
                       out_granted_address, out_status);
          end
        end
      end
      // stall bursts: mostly short, now and then long, runs of none between
      if (recv_left != 0) begin
        recv_left--;
      end else if (!idle_enable) begin
        recv_busy = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        recv_busy = 1'b1;
        recv_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                : $urandom_range(0, 2);
      end else begin
        recv_busy = 1'b0;
        recv_left = $urandom_range(0, 7);
      end
      out_stall <= (hold_left != 0) || recv_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, grants_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window: base 0, full table. The driver just waits out the
    // clearing pass behind in_stall.
    queue_alloc(32'd0);                      // zero size: bad request
    queue_alloc(32'd1);                      // one byte rounds to block 0
    queue_alloc(32'd4097);                   // two blocks, 1 and 2
    queue_alloc(32'hFFFF_FFFF);              // far larger than the table
    queue_alloc(32'(MAX_BLOCKS * BLOCK_BYTES)); // only a partial run left
    queue_free(32'h0000_2005);               // misaligned, tail of a run
    queue_free(32'hFFFF_FFFF);               // past the table
    queue_free(32'h0000_1000);               // head of the two-block run
    queue_free(32'h0000_0000);
    queue_alloc(32'(MAX_BLOCKS * BLOCK_BYTES)); // whole table in one run
    queue_free(32'h0000_3000);               // mid-run, chain runs to the end
    queue_alloc(32'(3 * BLOCK_BYTES));       // lands right behind the cut
    queue_free(32'h0000_0000);               // chain crosses into the next run

    // Top of the address space: granted addresses wrap past zero.
    reconfigure(32'hFFFF_F000, 11'd4);
    queue_alloc(32'(BLOCK_BYTES));
    queue_alloc(32'd1);                      // block 1 sits at address 0
    queue_free(32'h0000_0000);
    queue_free(32'hFFFF_E000);               // below the base
    queue_free(32'hFFFF_F000);
    queue_alloc(32'(4 * BLOCK_BYTES));       // exactly fills the table
    queue_alloc(32'(5 * BLOCK_BYTES));       // one block too many

    // Shrink under live marks: the walk must stop at the new end.
    reconfigure(32'hFFFF_F000, 11'd2);
    queue_free(32'hFFFF_F000);
    queue_alloc(32'(2 * BLOCK_BYTES));

    // Grow back: the marks left beyond the short table show up again.
    reconfigure(32'hFFFF_F000, 11'd4);
    queue_free(32'h0000_1000);
    queue_alloc(32'(2 * BLOCK_BYTES));

    // Empty table: nothing fits and every free is out of range.
    reconfigure(32'h0000_0000, 11'd0);
    queue_alloc(32'(BLOCK_BYTES));
    queue_alloc(32'd0);
    queue_free(32'h0000_0000);
    feed_random(15);

    // Small table with the sender flat out while the receiver holds off,
    // so the block backs up and stalls its input.
    reconfigure(32'h0001_0000, 11'd8);
    idle_enable = 1'b0;
    @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    feed_random(40);
    idle_enable = 1'b1;
    feed_random(80);

    // Single block at the largest base.
    reconfigure(32'hFFFF_FFFF, 11'd1);
    feed_random(50);

    // A stretch with no gaps and no stalls at all.
    reconfigure(32'h4000_0000, 11'd32);
    idle_enable = 1'b0;
    feed_random(150);
    idle_enable = 1'b1;

    reconfigure(32'h8000_3000, 11'd64);
    feed_random(120);

    // Full depth, then a count past the depth that must clamp.
    reconfigure(32'h0000_0000, 11'd1024);
    feed_random(70);
    reconfigure(32'h00AB_C000, 11'd2047);
    feed_random(30);

    // Drain, then leave time for any stray late beat to show.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests over %0d heap windows: %0d granted, %0d out of space,",
             beats_sent, settings_tried, allocs_granted, allocs_refused);
    $display("%0d bad, %0d frees; %0d result beats checked, %0d mismatches, %0d still owed",
             bad_requests, frees_done, beats_checked, mismatches, grants_due.size());
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
